[src/asc_pkg.sv]
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, character codes, SGR codes and the color palette of the
// console cursor block.
// ----------------------------------------------------------------------------
`default_nettype none

package asc_pkg;

  // default geometry
  localparam int GLYPH_WIDTH_DEF  = 8;
  localparam int GLYPH_HEIGHT_DEF = 16;
  localparam int PARAM_DEPTH_DEF  = 8;
  localparam int MAX_COLUMNS_DEF  = 256;
  localparam int MAX_ROWS_DEF     = 256;

  // fixed field widths
  localparam int CHAR_W    = 8;
  localparam int PIXEL_W   = 13;
  localparam int COLOR_W   = 24;
  localparam int CURSOR_W  = 8;
  localparam int ORIGIN_W  = 12;
  localparam int SLOT_AW   = 3;   // widest parameter slot address
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_ESC    = 8'h1B;
  localparam logic [CHAR_W-1:0] CHAR_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CHAR_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CHAR_SGR    = 8'h6D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

  // SGR parameter codes
  localparam logic [7:0] SGR_BLACK    = 8'd0;
  localparam logic [7:0] SGR_SKIP     = 8'd1;
  localparam logic [7:0] SGR_FG_FIRST = 8'd30;
  localparam logic [7:0] SGR_FG_LAST  = 8'd37;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BRACKET,
    PH_PARAM,
    PH_AFTER
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ACC,
    CS_APPLY,
    CS_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] value;
  } slot_t;

  typedef struct packed {
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    slot_t              wr_slot;
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  glyph_code;
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color;
  } out_item_t;

  function automatic logic [COLOR_W-1:0] palette(input logic [2:0] sel);
    logic [COLOR_W-1:0] rgb;
    unique case (sel)
      3'd0:    rgb = 24'h000000;
      3'd1:    rgb = 24'h800000;
      3'd2:    rgb = 24'h008000;
      3'd3:    rgb = 24'h808000;
      3'd4:    rgb = 24'h010081;
      3'd5:    rgb = 24'h800080;
      3'd6:    rgb = 24'h008080;
      default: rgb = 24'hc0c0c0;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

[src/ansi_sgr_console_cursor.sv]
// ----------------------------------------------------------------------------
// ansi_sgr_console_cursor
// Text stream to glyph placement with ANSI SGR foreground color.
//
// Input channel (in_valid / in_stall / in_char_code): one byte per request.
// Output channel (out_valid / out_stall / out_*): one glyph request per
// printable byte, carrying the byte, its cell pixel position and the color.
// Configuration: cfg_wr_en with cfg_index 0 writes origin_x, 1 writes
// origin_y; other indexes are ignored. Write only while the block is idle.
// Newline, escape and other sequence bytes are taken without stalling; a digit
// inside a parameter stalls for a read-modify-write of the parameter store,
// and 'm' stalls while it walks up to PARAM_DEPTH - 1 parameter slots,
// one slot per cycle through the store's single read port.
// A taken printable byte is loaded into the output register once that is free.
// A pending result waits in the output register under out_stall; further
// bytes are taken until a second printable byte needs that register.
// Reset (rst_n low, synchronous) clears the cursor, color, origins and
// parser; the parameter store is not reset, an escape clears its slot 0.
// ----------------------------------------------------------------------------
`default_nettype none

module ansi_sgr_console_cursor #(
  parameter int GLYPH_WIDTH  = asc_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = asc_pkg::GLYPH_HEIGHT_DEF,
  parameter int PARAM_DEPTH  = asc_pkg::PARAM_DEPTH_DEF,
  parameter int MAX_COLUMNS  = asc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS     = asc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [asc_pkg::CHAR_W-1:0]       in_char_code,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [asc_pkg::CHAR_W-1:0]            out_glyph_code,
  output logic [asc_pkg::PIXEL_W-1:0]           out_pixel_x,
  output logic [asc_pkg::PIXEL_W-1:0]           out_pixel_y,
  output logic [asc_pkg::COLOR_W-1:0]           out_color,
  input  wire logic                             cfg_wr_en,
  input  wire logic [asc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [asc_pkg::ORIGIN_W-1:0]     cfg_data
);
  import asc_pkg::*;

  mem_req_t  mem_req;
  slot_t     rd_slot;
  logic      out_free;
  logic      out_load;
  out_item_t out_item;

  asc_ctrl #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .PARAM_DEPTH  (PARAM_DEPTH),
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mem_req      (mem_req),
    .rd_slot      (rd_slot),
    .out_free     (out_free),
    .out_load     (out_load),
    .out_item     (out_item)
  );

  asc_param_ram #(
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_param_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_slot (rd_slot)
  );

  asc_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (out_load),
    .item           (out_item),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_glyph_code (out_glyph_code),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_color      (out_color)
  );

endmodule

`default_nettype wire

[src/asc_param_ram.sv]
// ----------------------------------------------------------------------------
// asc_param_ram
// SGR parameter store: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_param_ram #(
  parameter int PARAM_DEPTH = asc_pkg::PARAM_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire asc_pkg::mem_req_t req,
  output asc_pkg::slot_t        rd_slot
);
  import asc_pkg::*;

  localparam int IdxW = $clog2(PARAM_DEPTH);

  slot_t mem [PARAM_DEPTH];
  slot_t rd_slot_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IdxW-1:0]] <= req.wr_slot;
    end
    if (req.rd_en) begin
      rd_slot_r <= mem[req.rd_addr[IdxW-1:0]];
    end
  end

  assign rd_slot = rd_slot_r;

endmodule

`default_nettype wire

[src/asc_out_reg.sv]
// ----------------------------------------------------------------------------
// asc_out_reg
// Result register between the parser and the downstream receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_out_reg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire asc_pkg::out_item_t               item,
  output logic                                  free,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [asc_pkg::CHAR_W-1:0]            out_glyph_code,
  output logic [asc_pkg::PIXEL_W-1:0]           out_pixel_x,
  output logic [asc_pkg::PIXEL_W-1:0]           out_pixel_y,
  output logic [asc_pkg::COLOR_W-1:0]           out_color
);
  import asc_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  // slot can take a new request when empty or being drained this cycle
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  assign out_valid      = valid_r;
  assign out_glyph_code = item_r.glyph_code;
  assign out_pixel_x    = item_r.pixel_x;
  assign out_pixel_y    = item_r.pixel_y;
  assign out_color      = item_r.color;

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || !out_stall))
    else $error("result loaded over a pending result");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |=> valid_r)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

[src/asc_ctrl.sv]
// ----------------------------------------------------------------------------
// asc_ctrl
// Byte parser, cursor and color state, and the sequencer that walks the
// parameter store on 'm'.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_ctrl #(
  parameter int GLYPH_WIDTH  = asc_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = asc_pkg::GLYPH_HEIGHT_DEF,
  parameter int PARAM_DEPTH  = asc_pkg::PARAM_DEPTH_DEF,
  parameter int MAX_COLUMNS  = asc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS     = asc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [asc_pkg::CHAR_W-1:0]       in_char_code,
  input  wire logic                             cfg_wr_en,
  input  wire logic [asc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [asc_pkg::ORIGIN_W-1:0]     cfg_data,
  output asc_pkg::mem_req_t                     mem_req,
  input  wire asc_pkg::slot_t                   rd_slot,
  input  wire logic                             out_free,
  output logic                                  out_load,
  output asc_pkg::out_item_t                    out_item
);
  import asc_pkg::*;

  localparam int IdxW = $clog2(PARAM_DEPTH);

  ctrl_state_t              state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [IdxW-1:0]          index_r, index_nxt;
  logic [IdxW-1:0]          cnt_r, cnt_nxt;
  logic                     skip_r, skip_nxt;
  logic [CHAR_W-1:0]        char_r, char_nxt;
  logic [COLOR_W-1:0]       color_r, color_nxt;
  logic [CURSOR_W-1:0]      col_r, col_nxt;
  logic [CURSOR_W-1:0]      row_r, row_nxt;
  logic [ORIGIN_W-1:0]      origin_x_r, origin_y_r;

  logic                     accept;
  logic [CHAR_W-1:0]        c;
  logic                     is_digit;
  logic [IdxW-1:0]          idx_inc;
  logic [IdxW-1:0]          judge_idx;
  logic [7:0]               acc_value;
  logic [2:0]               fg_off;
  logic [CHAR_W-1:0]        emit_char;
  logic                     emit;

  assign in_stall = (state_r != CS_IDLE);
  assign accept   = in_valid && (state_r == CS_IDLE);
  assign c        = in_char_code;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign idx_inc  = (index_r < IdxW'(PARAM_DEPTH - 1)) ? index_r + 1'b1 : index_r;

  // value * 10 + digit, wraps at 8 bits
  assign acc_value = {rd_slot.value[4:0], 3'b000} + {rd_slot.value[6:0], 1'b0}
                   + (char_r - CHAR_ZERO);
  assign fg_off    = 3'(rd_slot.value - SGR_FG_FIRST);

  assign out_item.glyph_code = emit_char;
  assign out_item.pixel_x    = PIXEL_W'(col_r) * PIXEL_W'(GLYPH_WIDTH) + PIXEL_W'(origin_x_r);
  assign out_item.pixel_y    = PIXEL_W'(row_r) * PIXEL_W'(GLYPH_HEIGHT) + PIXEL_W'(origin_y_r);
  assign out_item.color      = color_r;
  assign out_load            = emit;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    index_nxt  = index_r;
    cnt_nxt    = cnt_r;
    skip_nxt   = skip_r;
    char_nxt   = char_r;
    color_nxt  = color_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    judge_idx  = index_r;
    emit       = 1'b0;
    emit_char  = char_r;
    mem_req    = '0;

    unique case (state_r)
      CS_IDLE: begin
        emit_char = c;
        if (accept) begin
          if (c == CHAR_NL) begin
            if (row_r < CURSOR_W'(MAX_ROWS - 1)) begin
              row_nxt = row_r + 1'b1;
            end
            col_nxt = '0;
          end else if (c == CHAR_ESC) begin
            index_nxt             = '0;
            phase_nxt             = PH_BRACKET;
            mem_req.wr_en         = 1'b1;
            mem_req.wr_addr       = '0;
            mem_req.wr_slot.empty = 1'b1;
            mem_req.wr_slot.value = '0;
          end else if (phase_r == PH_BRACKET) begin
            if (c == CHAR_LBRACK) begin
              phase_nxt = PH_PARAM;
            end
          end else if (phase_r == PH_PARAM && is_digit) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = SLOT_AW'(index_r);
            char_nxt        = c;
            state_nxt       = CS_ACC;
          end else if (phase_r == PH_PARAM || phase_r == PH_AFTER) begin
            // in a parameter a non-digit ends it and opens the next slot; then judge the byte
            if (phase_r == PH_PARAM) begin
              judge_idx             = idx_inc;
              index_nxt             = idx_inc;
              phase_nxt             = PH_AFTER;
              mem_req.wr_en         = 1'b1;
              mem_req.wr_addr       = SLOT_AW'(idx_inc);
              mem_req.wr_slot.empty = 1'b1;
              mem_req.wr_slot.value = '0;
            end
            if (c == CHAR_SEMI) begin
              phase_nxt = PH_PARAM;
            end else if (c == CHAR_SGR) begin
              phase_nxt = PH_IDLE;
              if (judge_idx != '0) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                cnt_nxt         = '0;
                skip_nxt        = 1'b0;
                state_nxt       = CS_APPLY;
              end
            end
          end else if (out_free) begin
            emit = 1'b1;
            if (col_r < CURSOR_W'(MAX_COLUMNS - 1)) begin
              col_nxt = col_r + 1'b1;
            end
          end else begin
            char_nxt  = c;
            state_nxt = CS_EMIT;
          end
        end
      end

      CS_ACC: begin
        mem_req.wr_en         = 1'b1;
        mem_req.wr_addr       = SLOT_AW'(index_r);
        mem_req.wr_slot.empty = 1'b0;
        mem_req.wr_slot.value = acc_value;
        state_nxt             = CS_IDLE;
      end

      CS_APPLY: begin
        skip_nxt = 1'b0;
        if (!skip_r && !rd_slot.empty) begin
          if (rd_slot.value == SGR_SKIP) begin
            skip_nxt = 1'b1;
          end else if (rd_slot.value == SGR_BLACK) begin
            color_nxt = '0;
          end else if (rd_slot.value >= SGR_FG_FIRST && rd_slot.value <= SGR_FG_LAST) begin
            color_nxt = palette(fg_off);
          end
        end
        if ((IdxW + 1)'(cnt_r) + 1'b1 == (IdxW + 1)'(index_r)) begin
          state_nxt = CS_IDLE;
        end else begin
          cnt_nxt         = cnt_r + 1'b1;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = SLOT_AW'(cnt_r + 1'b1);
        end
      end

      CS_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = CS_IDLE;
          if (col_r < CURSOR_W'(MAX_COLUMNS - 1)) begin
            col_nxt = col_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      phase_r <= PH_IDLE;
      index_r <= '0;
      cnt_r   <= '0;
      skip_r  <= 1'b0;
      color_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      index_r <= index_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      color_r <= color_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_ORIGIN_X) begin
        origin_x_r <= cfg_data;
      end else if (cfg_index == CFG_ORIGIN_Y) begin
        origin_y_r <= cfg_data;
      end
    end
  end

  a_apply_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_APPLY) |-> (cnt_r < index_r))
    else $error("apply walk beyond last parameter");

  // closing a parameter on 'm' writes the new slot while slot 0 is read
  a_no_mem_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en && mem_req.wr_addr == mem_req.rd_addr))
    else $error("parameter slot read and written in one cycle");

  a_esc_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && c == CHAR_ESC) |=> (index_r == '0 && phase_r == PH_BRACKET))
    else $error("escape did not restart the sequence");

endmodule

`default_nettype wire

[dv/ansi_sgr_console_cursor_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_console_cursor_chk
// Watches the byte, glyph and configuration ports of the console cursor
// block. It tracks the parser, cursor and color on its own and compares
// every glyph request, field by field, with the oldest one it predicted.
// ----------------------------------------------------------------------------

module ansi_sgr_console_cursor_chk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [asc_pkg::CHAR_W-1:0]   in_char_code,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [asc_pkg::CHAR_W-1:0]   out_glyph_code,
  input  logic [asc_pkg::PIXEL_W-1:0]  out_pixel_x,
  input  logic [asc_pkg::PIXEL_W-1:0]  out_pixel_y,
  input  logic [asc_pkg::COLOR_W-1:0]  out_color,
  input  logic                         cfg_wr_en,
  input  logic [asc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asc_pkg::ORIGIN_W-1:0] cfg_data,
  output int                           glyph_mismatches,
  output int                           glyphs_pending
);

  import asc_pkg::*;

  // foreground colors for sgr 30..37, entry 0 rightmost
  localparam logic [7:0][COLOR_W-1:0] FG_RGB = {
    24'hc0c0c0, 24'h008080, 24'h800080, 24'h010081,
    24'h808000, 24'h008000, 24'h800000, 24'h000000
  };

  phase_t              parse_phase;
  logic [SLOT_AW-1:0]  slot_idx;
  logic [7:0]          slot_val [8];
  logic                slot_empty [8];
  logic [COLOR_W-1:0]  fg_color;
  logic [CURSOR_W-1:0] cursor_col;
  logic [CURSOR_W-1:0] cursor_row;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  out_item_t           expected_glyphs [$];
  out_item_t           oldest_glyph;
  int                  fails = 0;

  task automatic track_console(input logic [CHAR_W-1:0] c);
    int        i;
    int        acc;
    int        px;
    int        py;
    logic [7:0] v;
    out_item_t g;
    if (c == CHAR_NL) begin
      if (cursor_row < MAX_ROWS_DEF - 1) cursor_row++;
      cursor_col = '0;
    end else if (c == CHAR_ESC) begin
      slot_idx      = '0;
      parse_phase   = PH_BRACKET;
      slot_val[0]   = '0;
      slot_empty[0] = 1'b1;
    end else if (parse_phase == PH_BRACKET) begin
      if (c == CHAR_LBRACK) parse_phase = PH_PARAM;
    end else if (parse_phase == PH_PARAM && c >= CHAR_ZERO && c <= CHAR_NINE) begin
      acc = int'(slot_val[slot_idx]) * 10 + int'(c - CHAR_ZERO);
      slot_val[slot_idx]   = acc[7:0];
      slot_empty[slot_idx] = 1'b0;
    end else if (parse_phase == PH_PARAM || parse_phase == PH_AFTER) begin
      // in a parameter a non-digit closes it; the byte is then judged as after one
      if (parse_phase == PH_PARAM) begin
        if (slot_idx < PARAM_DEPTH_DEF - 1) slot_idx++;
        slot_val[slot_idx]   = '0;
        slot_empty[slot_idx] = 1'b1;
        parse_phase = PH_AFTER;
      end
      if (c == CHAR_SEMI) begin
        parse_phase = PH_PARAM;
      end else if (c == CHAR_SGR) begin
        parse_phase = PH_IDLE;
        i = 0;
        while (i < int'(slot_idx)) begin
          if (!slot_empty[i % 8]) begin
            v = slot_val[i % 8];
            if (v == SGR_SKIP) begin
              i++;
            end else if (v == SGR_BLACK) begin
              fg_color = '0;
            end else if (v >= SGR_FG_FIRST && v <= SGR_FG_LAST) begin
              fg_color = FG_RGB[3'(v - SGR_FG_FIRST)];
            end
          end
          i++;
        end
      end
    end else begin
      px = int'(cursor_col) * GLYPH_WIDTH_DEF + int'(origin_x);
      py = int'(cursor_row) * GLYPH_HEIGHT_DEF + int'(origin_y);
      g.glyph_code = c;
      g.pixel_x    = px[PIXEL_W-1:0];
      g.pixel_y    = py[PIXEL_W-1:0];
      g.color      = fg_color;
      expected_glyphs.push_back(g);
      if (cursor_col < MAX_COLUMNS_DEF - 1) cursor_col++;
    end
  endtask

  task automatic report_field(input string name, input logic [COLOR_W-1:0] want,
                              input logic [COLOR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_phase = PH_IDLE;
      slot_idx    = '0;
      for (int k = 0; k < 8; k++) begin
        slot_val[k]   = '0;
        slot_empty[k] = 1'b1;
      end
      fg_color   = '0;
      cursor_col = '0;
      cursor_row = '0;
      origin_x   = '0;
      origin_y   = '0;
      expected_glyphs.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ORIGIN_X) origin_x = cfg_data;
        else if (cfg_index == CFG_ORIGIN_Y) origin_y = cfg_data;
      end
      // results first: a request taken this edge cannot come out the same edge
      if (out_valid && !out_stall) begin
        if (expected_glyphs.size() == 0) begin
          $display("%0t: unexpected glyph request, expected none, actual %h at (%0d,%0d) %h",
                   $time, out_glyph_code, out_pixel_x, out_pixel_y, out_color);
          fails++;
        end else begin
          oldest_glyph = expected_glyphs.pop_front();
          report_field("glyph_code", COLOR_W'(oldest_glyph.glyph_code), COLOR_W'(out_glyph_code));
          report_field("pixel_x", COLOR_W'(oldest_glyph.pixel_x), COLOR_W'(out_pixel_x));
          report_field("pixel_y", COLOR_W'(oldest_glyph.pixel_y), COLOR_W'(out_pixel_y));
          report_field("color", oldest_glyph.color, out_color);
        end
      end
      if (in_valid && !in_stall) track_console(in_char_code);
    end
    glyph_mismatches <= fails;
    glyphs_pending   <= expected_glyphs.size();
  end

endmodule

[dv/ansi_sgr_console_cursor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_console_cursor_tb
// Feeds the console cursor block a text stream: a short hand-made part with
// color sequences and their corner cases, then random text, newlines and
// well-formed and broken escape sequences under three idling patterns and
// several origin settings. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------

module ansi_sgr_console_cursor_tb;

  import asc_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_BYTES   = 560;
  localparam int LONG_LINE     = 270;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [ORIGIN_W-1:0]  ORIGIN_MAX = 12'hfff;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic [CHAR_W-1:0]   in_char_code = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [CHAR_W-1:0]   out_glyph_code;
  logic [PIXEL_W-1:0]  out_pixel_x;
  logic [PIXEL_W-1:0]  out_pixel_y;
  logic [COLOR_W-1:0]  out_color;
  logic                cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [ORIGIN_W-1:0] cfg_data     = '0;

  int in_idle_pct   = 18;
  int out_stall_pct = 56;
  int bytes_sent    = 0;
  int cycle_count   = 0;
  int glyph_mismatches;
  int glyphs_pending;

  ansi_sgr_console_cursor i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_glyph_code (out_glyph_code),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_color      (out_color),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  ansi_sgr_console_cursor_chk i_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_glyph_code   (out_glyph_code),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_color        (out_color),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .glyph_mismatches (glyph_mismatches),
    .glyphs_pending   (glyphs_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ansi_sgr_console_cursor_tb: done, errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [CHAR_W-1:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_decimal(input int v);
    if (v >= 100) send_byte(CHAR_W'(CHAR_ZERO + (v / 100) % 10));
    if (v >= 10) send_byte(CHAR_W'(CHAR_ZERO + (v / 10) % 10));
    send_byte(CHAR_W'(CHAR_ZERO + v % 10));
  endtask

  function automatic logic [CHAR_W-1:0] pick_glyph();
    logic [CHAR_W-1:0] b;
    b = CHAR_W'($urandom_range(255));
    while (b == CHAR_NL || b == CHAR_ESC) b = CHAR_W'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_sequence_byte();
    logic [CHAR_W-1:0] b;
    case ($urandom_range(5))
      0, 1:    b = CHAR_W'(CHAR_ZERO + $urandom_range(9));
      2:       b = CHAR_SEMI;
      3:       b = CHAR_LBRACK;
      4:       b = CHAR_SGR;
      default: b = CHAR_W'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic send_param();
    int pick;
    pick = $urandom_range(9);
    if (pick == 1) begin
      send_decimal(SGR_BLACK);
    end else if (pick == 2) begin
      send_decimal(SGR_SKIP);
    end else if (pick >= 3 && pick <= 5) begin
      send_decimal(SGR_FG_FIRST + $urandom_range(7));
    end else if (pick >= 6 && pick <= 7) begin
      send_decimal($urandom_range(255));
    end else if (pick >= 8) begin
      // long digit strings wrap the value
      repeat ($urandom_range(5, 1)) send_byte(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
    end
    // pick 0 leaves the slot empty
  endtask

  task automatic random_stream(input int target);
    int kind;
    int n;
    while (bytes_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        send_byte(CHAR_ESC);
        send_byte(CHAR_LBRACK);
        n = $urandom_range(10, 1);
        for (int k = 0; k < n; k++) begin
          if (k > 0) send_byte(CHAR_SEMI);
          send_param();
          if ($urandom_range(19) == 0) send_byte(CHAR_NL);
        end
        send_byte(CHAR_SGR);
      end else if (kind < 62) begin
        repeat ($urandom_range(12, 1)) send_byte(pick_glyph());
      end else if (kind < 70) begin
        send_byte(CHAR_NL);
      end else if (kind < 78) begin
        // blank lines push the row toward its limit
        repeat ($urandom_range(30, 5)) send_byte(CHAR_NL);
      end else if (kind < 90) begin
        send_byte(CHAR_ESC);
        repeat ($urandom_range(6, 0)) send_byte(pick_sequence_byte());
      end else begin
        send_byte(CHAR_W'($urandom_range(255)));
      end
    end
  endtask

  // block must be idle before a register write
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (glyphs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_origins(input logic [ORIGIN_W-1:0] x, input logic [ORIGIN_W-1:0] y);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ORIGIN_X;
    cfg_data  <= x;
    @(posedge clk);
    // write to an unused index must change nothing
    cfg_index <= CFG_SPARE;
    cfg_data  <= ORIGIN_W'($urandom);
    @(posedge clk);
    cfg_index <= CFG_ORIGIN_Y;
    cfg_data  <= y;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_origins(ORIGIN_MAX, ORIGIN_MAX);

    send_byte(8'hff);
    // skip over green, then an empty slot, then yellow
    send_byte(CHAR_ESC);
    send_byte(CHAR_LBRACK);
    send_decimal(SGR_SKIP);
    send_byte(CHAR_SEMI);
    send_decimal(32);
    send_byte(CHAR_SEMI);
    send_byte(CHAR_SEMI);
    send_decimal(33);
    send_byte(CHAR_SGR);
    send_byte("C");
    // stray byte before '[', wrapping value, newline inside, digit after stop
    send_byte(CHAR_ESC);
    send_byte("x");
    send_byte(CHAR_LBRACK);
    send_decimal(286);
    send_byte(CHAR_NL);
    send_byte("y");
    send_byte(CHAR_W'(CHAR_ZERO + 7));
    send_byte(CHAR_SGR);
    send_byte("D");

    random_stream(bytes_sent + PHASE_BYTES);
    settle();
    set_origins('0, '0);
    in_idle_pct   = 56;
    out_stall_pct = 18;

    // one line long enough to pin the column
    send_byte(CHAR_NL);
    repeat (LONG_LINE) send_byte(pick_glyph());
    random_stream(bytes_sent + PHASE_BYTES - LONG_LINE);
    settle();
    set_origins(ORIGIN_W'($urandom), ORIGIN_W'($urandom));
    in_idle_pct   = 0;
    out_stall_pct = 0;

    random_stream(bytes_sent + PHASE_BYTES);
    settle();

    if (glyph_mismatches == 0) begin
      $display("ansi_sgr_console_cursor_tb: done, clean");
    end else begin
      $display("ansi_sgr_console_cursor_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
src/asc_pkg.sv
src/asc_param_ram.sv
src/asc_out_reg.sv
src/asc_ctrl.sv
src/ansi_sgr_console_cursor.sv
dv/ansi_sgr_console_cursor_chk.sv
dv/ansi_sgr_console_cursor_tb.sv
